// ----- hw/rtl/kmeans_pkg.sv -----
// Shared constants and types for the k-means engine.
// No dependencies.
package kmeans_pkg;
  localparam int MAX_POINTS   = 1024;
  localparam int MAX_CLUSTERS = 8;
  localparam int COORD_WIDTH  = 16;
  localparam int PW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_CLUSTERS);
  localparam int NW  = PW + 1;
  localparam int SW  = COORD_WIDTH + PW + 1;
  localparam int DW  = COORD_WIDTH + 1;
  localparam int QW  = 2 * DW + 1;

  localparam logic [1:0] CMD_LOAD_POINT  = 2'd0;
  localparam logic [1:0] CMD_LOAD_CENTER = 2'd1;
  localparam logic [1:0] CMD_RUN         = 2'd2;

  localparam logic [1:0] REG_POINT_COUNT   = 2'd0;
  localparam logic [1:0] REG_CLUSTER_COUNT = 2'd1;
  localparam logic [1:0] REG_ITER_LIMIT    = 2'd2;

  typedef struct packed {
    logic clear;
    logic dist_en;
    logic accum;
    logic div_start;
    logic emit;
    logic [PW-1:0] pidx;
    logic [CW-1:0] cidx;
    logic          first;
  } ctrl_t;

  typedef struct packed {
    logic div_done;
    logic empty;
  } stat_t;
endpackage

// ----- hw/rtl/kmeans_div.sv -----
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on kmeans_pkg.
module kmeans_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [kmeans_pkg::SW-1:0] num,
  input  logic [kmeans_pkg::NW-1:0] den,
  output logic done,
  output logic signed [kmeans_pkg::COORD_WIDTH-1:0] quo
);
  localparam int W  = kmeans_pkg::SW;
  localparam int CNTW = $clog2(W + 1);
  logic [W-1:0] q, mag;
  logic [W:0] rem;
  logic [kmeans_pkg::NW-1:0] d;
  logic neg, run;
  logic [CNTW-1:0] cnt;
  logic [W:0] trial;
  logic [W-1:0] qfix;

  assign trial = {rem[W-1:0], q[W-1]};
  assign mag   = num[W-1] ? W'(-num) : W'(num);
  assign qfix  = neg ? W'(-q) : q;
  assign quo   = qfix[kmeans_pkg::COORD_WIDTH-1:0];

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      run <= 1'b1;
      q <= mag;
      rem <= '0;
      d <= den;
      neg <= num[W-1];
      cnt <= CNTW'(W);
    end else if (run) begin
      if (trial >= {{(W+1-kmeans_pkg::NW){1'b0}}, d}) begin
        rem <= trial - {{(W+1-kmeans_pkg::NW){1'b0}}, d};
        q <= {q[W-2:0], 1'b1};
      end else begin
        rem <= trial;
        q <= {q[W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CNTW'(1)) begin
        run <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// ----- hw/rtl/kmeans_datapath.sv -----
// Point/center stores, distance unit, accumulators and update logic.
// Depends on kmeans_pkg and kmeans_div.
module kmeans_datapath (
  input  logic clk,
  input  logic rst,
  input  logic load_point,
  input  logic load_center,
  input  logic [kmeans_pkg::PW-1:0] slot,
  input  logic signed [kmeans_pkg::COORD_WIDTH-1:0] coord_x,
  input  logic signed [kmeans_pkg::COORD_WIDTH-1:0] coord_y,
  input  kmeans_pkg::ctrl_t ctrl,
  input  logic div_y,
  input  logic write_x,
  input  logic write_y,
  output kmeans_pkg::stat_t stat,
  output logic signed [kmeans_pkg::COORD_WIDTH-1:0] out_x,
  output logic signed [kmeans_pkg::COORD_WIDTH-1:0] out_y,
  output logic [kmeans_pkg::NW-1:0] out_count
);
  localparam int CWD = kmeans_pkg::COORD_WIDTH;
  localparam int K   = kmeans_pkg::MAX_CLUSTERS;
  logic signed [CWD-1:0] px_mem [kmeans_pkg::MAX_POINTS];
  logic signed [CWD-1:0] py_mem [kmeans_pkg::MAX_POINTS];
  logic signed [CWD-1:0] cx [K];
  logic signed [CWD-1:0] cy [K];
  logic signed [kmeans_pkg::SW-1:0] sx [K];
  logic signed [kmeans_pkg::SW-1:0] sy [K];
  logic [kmeans_pkg::NW-1:0] cnt [K];
  logic signed [CWD-1:0] px, py;
  logic [kmeans_pkg::QW-1:0] dq, best_d;
  logic [kmeans_pkg::CW-1:0] best, dcidx;
  logic dfirst, dvalid;
  logic signed [kmeans_pkg::DW-1:0] ddx, ddy;
  logic [kmeans_pkg::DW-1:0] adx, ady;
  logic [2*kmeans_pkg::DW-1:0] mx, my;
  logic div_done;
  logic signed [CWD-1:0] quo;

  // point read, registered
  always_ff @(posedge clk) begin
    if (load_point) begin
      px_mem[slot] <= coord_x;
      py_mem[slot] <= coord_y;
    end
    px <= px_mem[ctrl.pidx];
    py <= py_mem[ctrl.pidx];
  end

  assign ddx = kmeans_pkg::DW'(px) - kmeans_pkg::DW'(cx[ctrl.cidx]);
  assign ddy = kmeans_pkg::DW'(py) - kmeans_pkg::DW'(cy[ctrl.cidx]);
  assign adx = ddx[kmeans_pkg::DW-1] ? kmeans_pkg::DW'(-ddx) : kmeans_pkg::DW'(ddx);
  assign ady = ddy[kmeans_pkg::DW-1] ? kmeans_pkg::DW'(-ddy) : kmeans_pkg::DW'(ddy);
  assign dq = kmeans_pkg::QW'(mx) + kmeans_pkg::QW'(my);

  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid <= 1'b0;
    end else begin
      dvalid <= ctrl.dist_en;
    end
    mx <= adx * adx;
    my <= ady * ady;
    dcidx <= ctrl.cidx;
    dfirst <= ctrl.first;
    if (dvalid && (dfirst || dq < best_d)) begin
      best_d <= dq;
      best <= dcidx;
    end
  end

  always_ff @(posedge clk) begin
    if (load_center && slot < kmeans_pkg::PW'(K)) begin
      cx[slot[kmeans_pkg::CW-1:0]] <= coord_x;
      cy[slot[kmeans_pkg::CW-1:0]] <= coord_y;
    end
    if (write_x) cx[ctrl.cidx] <= quo;
    if (write_y) cy[ctrl.cidx] <= quo;
    if (ctrl.clear) begin
      for (int j = 0; j < K; j++) begin
        sx[j] <= '0;
        sy[j] <= '0;
        cnt[j] <= '0;
      end
    end else if (ctrl.accum) begin
      sx[best] <= sx[best] + kmeans_pkg::SW'(px);
      sy[best] <= sy[best] + kmeans_pkg::SW'(py);
      cnt[best] <= cnt[best] + 1'b1;
    end
  end

  kmeans_div u_div (
    .clk(clk), .rst(rst), .start(ctrl.div_start),
    .num(div_y ? sy[ctrl.cidx] : sx[ctrl.cidx]),
    .den(cnt[ctrl.cidx]), .done(div_done), .quo(quo)
  );

  assign stat.div_done = div_done;
  assign stat.empty = (cnt[ctrl.cidx] == '0);
  assign out_x = cx[ctrl.cidx];
  assign out_y = cy[ctrl.cidx];
  assign out_count = cnt[ctrl.cidx];
endmodule

// ----- hw/rtl/kmeans_ctrl.sv -----
// Sequencer for the assign, update and emit phases of a run.
// Depends on kmeans_pkg.
module kmeans_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic run_start,
  input  logic [kmeans_pkg::NW-1:0] n_eff,
  input  logic [kmeans_pkg::CW:0] k_eff,
  input  logic [15:0] iter_limit,
  input  kmeans_pkg::stat_t stat,
  output kmeans_pkg::ctrl_t ctrl,
  output logic div_y,
  output logic write_x,
  output logic write_y,
  output logic busy,
  output logic emit_last
);
  localparam logic [2:0] S_IDLE = 3'd0, S_PASS = 3'd1, S_DIST = 3'd2,
                         S_ACC = 3'd3, S_UPD = 3'd4, S_DIV = 3'd5, S_EMIT = 3'd6;
  localparam int CW = kmeans_pkg::CW;
  localparam int PW = kmeans_pkg::PW;
  logic [2:0] state;
  logic [15:0] iter;
  logic [PW:0] pidx;
  logic [CW:0] cidx;
  logic [2:0] wait_cnt;
  logic last_c, last_p;

  assign last_c = (cidx + 1'b1 == k_eff);
  assign last_p = (pidx + 1'b1 >= n_eff);
  assign busy = (state != S_IDLE);
  assign emit_last = last_c;

  always_comb begin
    ctrl = '0;
    ctrl.pidx = pidx[PW-1:0];
    ctrl.cidx = cidx[CW-1:0];
    ctrl.first = (cidx == '0);
    // counts also clear at run start, so a zero-pass run reports empty clusters
    ctrl.clear = (state == S_PASS) || (state == S_IDLE && run_start);
    ctrl.dist_en = (state == S_DIST);
    ctrl.accum = (state == S_ACC) && (wait_cnt == 3'd0);
    ctrl.div_start = (state == S_UPD) && !stat.empty;
    ctrl.emit = (state == S_EMIT);
  end
  assign write_x = (state == S_DIV) && stat.div_done && !div_y;
  assign write_y = (state == S_DIV) && stat.div_done && div_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      div_y <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (run_start) begin
          iter <= iter_limit;
          cidx <= '0;
          state <= (iter_limit == '0) ? S_EMIT : S_PASS;
        end
        S_PASS: begin
          pidx <= '0;
          cidx <= '0;
          wait_cnt <= 3'd3;
          // no point when n is zero: go straight to update
          state <= (n_eff == '0) ? S_UPD : S_ACC;
        end
        // S_ACC starts a center sweep, then drains the pipeline and accumulates
        S_ACC: begin
          if (wait_cnt == 3'd3) begin
            wait_cnt <= 3'd2;
            state <= S_DIST;
          end else if (wait_cnt != 3'd0) begin
            wait_cnt <= wait_cnt - 1'b1;
          end else begin
            cidx <= '0;
            if (last_p) begin
              state <= S_UPD;
            end else begin
              pidx <= pidx + 1'b1;
              wait_cnt <= 3'd3;
            end
          end
        end
        S_DIST: begin
          if (last_c) begin
            cidx <= '0;
            state <= S_ACC;
          end else begin
            cidx <= cidx + 1'b1;
          end
        end
        S_UPD: begin
          if (!stat.empty) begin
            state <= S_DIV;
          end else if (last_c) begin
            cidx <= '0;
            iter <= iter - 1'b1;
            state <= (iter == 16'd1) ? S_EMIT : S_PASS;
          end else begin
            cidx <= cidx + 1'b1;
          end
        end
        S_DIV: if (stat.div_done) begin
          if (!div_y) begin
            div_y <= 1'b1;
            state <= S_UPD;
          end else begin
            div_y <= 1'b0;
            if (last_c) begin
              cidx <= '0;
              iter <= iter - 1'b1;
              state <= (iter == 16'd1) ? S_EMIT : S_PASS;
            end else begin
              cidx <= cidx + 1'b1;
              state <= S_UPD;
            end
          end
        end
        S_EMIT: begin
          cidx <= cidx + 1'b1;
          if (last_c) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) write_x |-> !write_y)
    else $error("x and y center written together");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && last_c) |=> state == S_IDLE)
    else $error("emit did not end after last cluster");
  assert property (@(posedge clk) disable iff (rst) ctrl.accum |-> !ctrl.clear)
    else $error("accumulate during clear");
endmodule

// ----- hw/rtl/kmeans_lloyd_cluster_engine.sv -----
// Top level of the k-means engine: ports, registers, result outputs.
// Depends on kmeans_pkg, kmeans_ctrl, kmeans_datapath.
//
// Usage:
//  Command channel: start/busy. A command transfers at a clock edge with
//  start high and busy low. Load-point and load-center commands leave
//  busy low, so loads may come every cycle. A run command raises busy.
//  Each pass has an assign sweep (one center distance per cycle per
//  point, plus memory read and multiplier latency) and a center update,
//  where the bit-serial divider takes one quotient bit per cycle. After
//  iteration_limit passes, k results come out on consecutive cycles,
//  each marked by result_valid for one cycle, last on the final one.
//  The receiver cannot stall: results must be taken as they appear.
//  Config channel: cfg_valid/cfg_ready, always ready; write only while idle.
//  Reset (rst, synchronous) returns registers to point_count 1,
//  cluster_count 1, iteration_limit 16 and idles the sequencer; point and
//  center stores are not cleared and must be loaded before a run.
module kmeans_lloyd_cluster_engine (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] cmd,
  input  logic [9:0] slot,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  output logic result_valid,
  output logic [2:0] center_index,
  output logic signed [15:0] center_x,
  output logic signed [15:0] center_y,
  output logic [10:0] member_count,
  output logic last
);
  localparam int CW = kmeans_pkg::CW;
  localparam int NW = kmeans_pkg::NW;
  logic [10:0] point_count;
  logic [3:0] cluster_count;
  logic [15:0] iteration_limit;
  logic [NW-1:0] n_eff;
  logic [CW:0] k_eff;
  logic accept, div_y, write_x, write_y, emit_last;
  kmeans_pkg::ctrl_t ctrl;
  kmeans_pkg::stat_t stat;
  logic signed [15:0] dx, dy;
  logic [NW-1:0] dcount;

  assign cfg_ready = 1'b1;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= 11'd1;
      cluster_count <= 4'd1;
      iteration_limit <= 16'd16;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        kmeans_pkg::REG_POINT_COUNT:   point_count <= cfg_data[10:0];
        kmeans_pkg::REG_CLUSTER_COUNT: cluster_count <= cfg_data[3:0];
        kmeans_pkg::REG_ITER_LIMIT:    iteration_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturate counts into their usable range
  assign n_eff = (point_count > 11'(kmeans_pkg::MAX_POINTS))
               ? NW'(kmeans_pkg::MAX_POINTS) : point_count;
  always_comb begin
    priority if (cluster_count == '0) k_eff = (CW+1)'(1);
    else if (cluster_count > 4'(kmeans_pkg::MAX_CLUSTERS))
      k_eff = (CW+1)'(kmeans_pkg::MAX_CLUSTERS);
    else k_eff = cluster_count[CW:0];
  end

  kmeans_ctrl u_ctrl (
    .clk(clk), .rst(rst), .run_start(accept && cmd == kmeans_pkg::CMD_RUN),
    .n_eff(n_eff), .k_eff(k_eff), .iter_limit(iteration_limit), .stat(stat),
    .ctrl(ctrl), .div_y(div_y), .write_x(write_x), .write_y(write_y),
    .busy(busy), .emit_last(emit_last)
  );

  kmeans_datapath u_dp (
    .clk(clk), .rst(rst),
    .load_point(accept && cmd == kmeans_pkg::CMD_LOAD_POINT),
    .load_center(accept && cmd == kmeans_pkg::CMD_LOAD_CENTER),
    .slot(slot), .coord_x(coord_x), .coord_y(coord_y),
    .ctrl(ctrl), .div_y(div_y), .write_x(write_x), .write_y(write_y),
    .stat(stat), .out_x(dx), .out_y(dy), .out_count(dcount)
  );

  // registered result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctrl.emit;
    end
    center_index <= 3'(ctrl.cidx);
    center_x <= dx;
    center_y <= dy;
    member_count <= dcount;
    last <= emit_last;
  end

  assert property (@(posedge clk) disable iff (rst) result_valid |-> busy || last)
    else $error("result outside a run");
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |-> !ctrl.emit)
    else $error("emit continued after last");
  assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == kmeans_pkg::CMD_RUN) |=> busy)
    else $error("run did not raise busy");
endmodule

// ----- tb/tb.sv -----
// Testbench for kmeans_lloyd_cluster_engine: directed table, then random phases.
// Depends on kmeans_pkg and the engine RTL. Self-checking against an internal predictor.
`timescale 1ns / 100ps

module tb;
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int SETTLE      = 64;      // quiet cycles before a config write and at the end
  localparam int FILL_POINTS = 48;      // point slots loaded up front; runs stay within them
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [1:0] REG_UNKNOWN = 2'd3;

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic clk, rst;
  logic start, busy;
  logic [1:0] cmd;
  logic [9:0] slot;
  logic signed [15:0] coord_x, coord_y;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic result_valid;
  logic [2:0] center_index;
  logic signed [15:0] center_x, center_y;
  logic [10:0] member_count;
  logic last;

  kmeans_lloyd_cluster_engine dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .slot(slot), .coord_x(coord_x), .coord_y(coord_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .center_index(center_index),
    .center_x(center_x), .center_y(center_y),
    .member_count(member_count), .last(last)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // ---------------------------------------------------------------------------
  // Result record and the queue of centers still owed by the engine
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [2:0]         idx;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [10:0]        cnt;
    logic               lst;
  } center_rec_t;

  center_rec_t owed_centers[$];
  int mismatches = 0;
  longint unsigned cycles = 0;

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the stores and registers
  // ---------------------------------------------------------------------------
  longint pt_x[kmeans_pkg::MAX_POINTS], pt_y[kmeans_pkg::MAX_POINTS];
  longint ct_x[kmeans_pkg::MAX_CLUSTERS], ct_y[kmeans_pkg::MAX_CLUSTERS];
  longint unsigned members[kmeans_pkg::MAX_CLUSTERS];
  logic [10:0] r_points;
  logic [3:0]  r_clusters;
  logic [15:0] r_iters;

  function automatic longint unsigned dist2(longint ax, longint ay, longint bx, longint by);
    longint unsigned dx, dy;
    dx = (ax >= bx) ? ax - bx : bx - ax;
    dy = (ay >= by) ? ay - by : by - ay;
    return dx * dx + dy * dy;   // at most ~8.6e9, no carry into bit 64
  endfunction

  // One Lloyd pass: nearest center (lower index on tie), then truncated means.
  task automatic lloyd_pass(int n, int k);
    longint sx[kmeans_pkg::MAX_CLUSTERS], sy[kmeans_pkg::MAX_CLUSTERS];
    longint unsigned bd, d;
    int best;
    for (int j = 0; j < k; j++) begin
      sx[j] = 0; sy[j] = 0; members[j] = 0;
    end
    for (int i = 0; i < n; i++) begin
      best = 0;
      bd = dist2(pt_x[i], pt_y[i], ct_x[0], ct_y[0]);
      for (int j = 1; j < k; j++) begin
        d = dist2(pt_x[i], pt_y[i], ct_x[j], ct_y[j]);
        if (d < bd) begin
          bd = d; best = j;
        end
      end
      sx[best] += pt_x[i];
      sy[best] += pt_y[i];
      members[best]++;
    end
    // empty cluster keeps its center
    for (int j = 0; j < k; j++)
      if (members[j] != 0) begin
        ct_x[j] = sx[j] / longint'(members[j]);
        ct_y[j] = sy[j] / longint'(members[j]);
      end
  endtask

  // Apply one accepted command; a run queues k final centers.
  task automatic model_command(logic [1:0] c, logic [9:0] s, logic signed [15:0] x,
                               logic signed [15:0] y);
    int n, k;
    center_rec_t r;
    case (c)
      kmeans_pkg::CMD_LOAD_POINT: begin
        pt_x[s] = x; pt_y[s] = y;
      end
      kmeans_pkg::CMD_LOAD_CENTER: begin
        if (s < kmeans_pkg::MAX_CLUSTERS) begin
          ct_x[s] = x; ct_y[s] = y;
        end
      end
      kmeans_pkg::CMD_RUN: begin
        n = (r_points > kmeans_pkg::MAX_POINTS) ? kmeans_pkg::MAX_POINTS : int'(r_points);
        k = (r_clusters == 0) ? 1 : int'(r_clusters);
        if (k > kmeans_pkg::MAX_CLUSTERS) k = kmeans_pkg::MAX_CLUSTERS;
        for (int j = 0; j < k; j++) members[j] = 0;
        for (int it = 0; it < r_iters; it++) lloyd_pass(n, k);
        for (int j = 0; j < k; j++) begin
          r.idx = 3'(j); r.cx = 16'(ct_x[j]); r.cy = 16'(ct_y[j]);
          r.cnt = 11'(members[j]); r.lst = (j == k - 1);
          owed_centers = {owed_centers, r};
        end
      end
      default: ;  // unknown command: no effect
    endcase
  endtask

  function automatic void model_config(logic [1:0] i, logic [15:0] v);
    case (i)
      kmeans_pkg::REG_POINT_COUNT:   r_points   = v[10:0];
      kmeans_pkg::REG_CLUSTER_COUNT: r_clusters = v[3:0];
      kmeans_pkg::REG_ITER_LIMIT:    r_iters    = v;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Present one command and hold until it transfers (start high, busy low).
  // Leaves start high; the caller lowers it only if a gap follows.
  task automatic send_command(logic [1:0] c, logic [9:0] s, logic signed [15:0] x,
                              logic signed [15:0] y);
    start <= 1'b1; cmd <= c; slot <= s; coord_x <= x; coord_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    model_command(c, s, x, y);
  endtask

  // Mostly back-to-back, sometimes a short pause, rarely a long one.
  task automatic idle_gap();
    int p, g;
    p = $urandom_range(0, 99);
    g = (p < 65) ? 0 : (p < 93) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Register write, only once the engine has drained every owed center.
  task automatic write_reg(logic [1:0] i, logic [15:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (owed_centers.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= i; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_config(i, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_coord();
    int b;
    if ($urandom_range(0, 1)) return 16'($urandom());
    b = $urandom_range(0, 2);
    return 16'((b - 1) * 20000 + int'($urandom_range(0, 2000)) - 1000);  // three loose blobs
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {ROW_CMD, ROW_REG, ROW_RUN_FIXED} row_kind_t;
  typedef struct {
    row_kind_t          kind;
    logic [1:0]         op;     // command or register index
    logic [9:0]         s;
    logic signed [15:0] x, y;   // coordinates, or register data in x
    center_rec_t        fixed;  // typed result for ROW_RUN_FIXED (k = 1)
  } row_t;
  row_t table_rows[$];

  function automatic row_t cmd_row(logic [1:0] c, logic [9:0] s, logic signed [15:0] x,
                                   logic signed [15:0] y);
    row_t r;
    r.kind = ROW_CMD; r.op = c; r.s = s; r.x = x; r.y = y; r.fixed = '0;
    return r;
  endfunction

  function automatic row_t reg_row(logic [1:0] i, logic [15:0] v);
    row_t r;
    r = cmd_row(kmeans_pkg::CMD_LOAD_POINT, 10'd0, v, 16'sd0);
    r.kind = ROW_REG; r.op = i;
    return r;
  endfunction

  function automatic row_t fixed_run_row(logic signed [15:0] x, logic signed [15:0] y);
    row_t r;
    r = cmd_row(kmeans_pkg::CMD_RUN, 10'd0, 16'sd0, 16'sd0);
    r.kind = ROW_RUN_FIXED;
    r.fixed.idx = 3'd0; r.fixed.cx = x; r.fixed.cy = y;
    r.fixed.cnt = 11'd0; r.fixed.lst = 1'b1;
    return r;
  endfunction

  function automatic void add_row(row_t r);
    table_rows = {table_rows, r};
  endfunction

  initial begin
    // run on reset registers, then the coordinate extremes
    add_row(cmd_row(kmeans_pkg::CMD_RUN, 10'd0, 16'sd0, 16'sd0));
    add_row(cmd_row(kmeans_pkg::CMD_LOAD_POINT, 10'd0, 16'sh7fff, 16'sh7fff));
    add_row(cmd_row(kmeans_pkg::CMD_LOAD_POINT, 10'd1, -16'sh8000, -16'sh8000));
    add_row(cmd_row(kmeans_pkg::CMD_LOAD_POINT, 10'd1023, -16'sh8000, 16'sh7fff));
    add_row(cmd_row(kmeans_pkg::CMD_LOAD_CENTER, 10'd0, 16'sd0, 16'sd0));
    add_row(cmd_row(kmeans_pkg::CMD_LOAD_CENTER, 10'd1, 16'sh7fff, -16'sh8000));
    // equal centers: ties go to the lower index
    add_row(cmd_row(kmeans_pkg::CMD_LOAD_CENTER, 10'd2, 16'sd100, 16'sd100));
    add_row(cmd_row(kmeans_pkg::CMD_LOAD_CENTER, 10'd3, 16'sd100, 16'sd100));
    // out-of-range center slots and the unknown command are dropped
    add_row(cmd_row(kmeans_pkg::CMD_LOAD_CENTER, 10'd8, 16'sd5, 16'sd5));
    add_row(cmd_row(kmeans_pkg::CMD_LOAD_CENTER, 10'd1023, 16'sd7, 16'sd7));
    add_row(cmd_row(CMD_UNKNOWN, 10'd0, 16'sd9, 16'sd9));
    add_row(reg_row(kmeans_pkg::REG_POINT_COUNT, 16'd2));
    add_row(reg_row(kmeans_pkg::REG_CLUSTER_COUNT, 16'd2));
    add_row(reg_row(kmeans_pkg::REG_ITER_LIMIT, 16'd1));
    add_row(cmd_row(kmeans_pkg::CMD_RUN, 10'd0, 16'sd0, 16'sd0));
    add_row(reg_row(kmeans_pkg::REG_CLUSTER_COUNT, 16'd0));      // zero k acts as one
    add_row(cmd_row(kmeans_pkg::CMD_RUN, 10'd0, 16'sd0, 16'sd0));
    add_row(reg_row(kmeans_pkg::REG_CLUSTER_COUNT, 16'hffff));   // k saturates at 8
    add_row(reg_row(kmeans_pkg::REG_POINT_COUNT, 16'd0));        // all clusters empty
    add_row(cmd_row(kmeans_pkg::CMD_RUN, 10'd0, 16'sd0, 16'sd0));
    // every preloaded point over all eight clusters
    add_row(reg_row(kmeans_pkg::REG_POINT_COUNT, 16'(FILL_POINTS)));
    add_row(cmd_row(kmeans_pkg::CMD_RUN, 10'd0, 16'sd0, 16'sd0));
    // zero passes: center comes back as loaded, empty
    add_row(reg_row(kmeans_pkg::REG_CLUSTER_COUNT, 16'd1));
    add_row(reg_row(kmeans_pkg::REG_ITER_LIMIT, 16'd0));
    add_row(cmd_row(kmeans_pkg::CMD_LOAD_CENTER, 10'd0, -16'sh8000, 16'sh7fff));
    add_row(fixed_run_row(-16'sh8000, 16'sh7fff));
    add_row(reg_row(REG_UNKNOWN, 16'hbeef));                     // unknown register
    // longest pass count, no points: center still as loaded
    add_row(reg_row(kmeans_pkg::REG_POINT_COUNT, 16'd0));
    add_row(reg_row(kmeans_pkg::REG_ITER_LIMIT, 16'hffff));
    add_row(fixed_run_row(-16'sh8000, 16'sh7fff));
  end

  // ---------------------------------------------------------------------------
  // Result checker: strobe is sampled at the edge that ends its cycle
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    center_rec_t want, got;
    if (!rst && result_valid) begin
      got = {center_index, center_x, center_y, member_count, last};
      if (owed_centers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
      end else begin
        want = owed_centers.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"center mismatch: expected idx %0d x %0d y %0d cnt %0d last %0d,",
                      " got idx %0d x %0d y %0d cnt %0d last %0d"},
                     want.idx, want.cx, want.cy, want.cnt, want.lst,
                     got.idx, got.cx, got.cy, got.cnt, got.lst);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int p;
    logic [1:0] c;
    logic [9:0] s;
    rst <= 1'b1; start <= 1'b0; cmd <= '0; slot <= '0; coord_x <= '0; coord_y <= '0;
    cfg_valid <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    r_points = 11'd1; r_clusters = 4'd1; r_iters = 16'd16;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the low point slots and every center; point counts never exceed the fill.
    for (int i = 0; i < FILL_POINTS; i++) begin
      send_command(kmeans_pkg::CMD_LOAD_POINT, 10'(i), rand_coord(), rand_coord());
      idle_gap();
    end
    for (int i = 0; i < kmeans_pkg::MAX_CLUSTERS; i++) begin
      send_command(kmeans_pkg::CMD_LOAD_CENTER, 10'(i), rand_coord(), rand_coord());
      idle_gap();
    end

    foreach (table_rows[i]) begin
      case (table_rows[i].kind)
        ROW_REG: write_reg(table_rows[i].op, table_rows[i].x);
        ROW_CMD: send_command(table_rows[i].op, table_rows[i].s, table_rows[i].x,
                              table_rows[i].y);
        default: begin
          // the typed center replaces the predicted one
          send_command(table_rows[i].op, table_rows[i].s, table_rows[i].x, table_rows[i].y);
          owed_centers[owed_centers.size() - 1] = table_rows[i].fixed;
        end
      endcase
      idle_gap();
    end

    // Random phases: new settings, then a burst of loads and runs.
    for (int ph = 0; ph < 7; ph++) begin
      p = $urandom_range(0, 9);
      write_reg(kmeans_pkg::REG_POINT_COUNT,
                {5'($urandom_range(0, 31)),
                 11'((p == 0) ? $urandom_range(0, FILL_POINTS) : $urandom_range(1, 40))});
      write_reg(kmeans_pkg::REG_CLUSTER_COUNT,
                {12'($urandom_range(0, 4095)), 4'($urandom_range(0, 15))});
      write_reg(kmeans_pkg::REG_ITER_LIMIT, (p == 1) ? 16'd0 : 16'($urandom_range(1, 8)));
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNKNOWN, 16'($urandom()));
      for (int n = 0; n < 25; n++) begin
        p = $urandom_range(0, 99);
        if (p < 45) begin
          c = kmeans_pkg::CMD_LOAD_POINT;
          s = ($urandom_range(0, 3) == 0) ? 10'($urandom())
                                          : 10'($urandom_range(0, FILL_POINTS - 1));
        end else if (p < 65) begin
          c = kmeans_pkg::CMD_LOAD_CENTER;
          s = ($urandom_range(0, 5) == 0) ? 10'($urandom()) : 10'($urandom_range(0, 7));
        end else if (p < 90) begin
          c = kmeans_pkg::CMD_RUN; s = 10'($urandom());
        end else begin
          c = CMD_UNKNOWN; s = 10'($urandom());
        end
        send_command(c, s, rand_coord(), rand_coord());
        idle_gap();
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (owed_centers.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
